>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the scan sequencer.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under a synchronous reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
// Next-cycle implication under a synchronous reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/dacs_pkg.sv
// Package for the dual converter scan sequencer: widths, register codes, types.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps
package dacs_pkg;

   localparam int DEFAULT_PAIRS = 4;

   localparam int NOW_W      = 32;
   localparam int SAMPLE_W   = 24;
   localparam int CHAN_W     = 3;
   localparam int PAIR_W     = 2;
   localparam int MASK_W     = 8;
   localparam int ERR_W      = 8;
   localparam int RESTART_W  = 16;
   localparam int INTERVAL_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [MASK_W-1:0]     MASK_RESET   = 8'hFF;
   localparam logic [INTERVAL_W-1:0] RETRY_RESET  = 16'd1000;
   localparam logic [ERR_W-1:0]      LIMIT_RESET  = 8'd3;
   localparam logic [ERR_W-1:0]      ERR_MAX      = 8'hFF;
   localparam logic [RESTART_W-1:0]  RESTART_MAX  = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHANNEL_MASK   = 3'd0,
      REG_ENABLE_FIRST   = 3'd1,
      REG_ENABLE_SECOND  = 3'd2,
      REG_RETRY_INTERVAL = 3'd3,
      REG_ERROR_LIMIT    = 3'd4
   } csr_reg_type;

   // What one converter lane reports for the current poll.
   typedef struct packed {
      logic              accessed;
      logic              fail_hit;
      logic              emit;
      logic [PAIR_W-1:0] next_pair;
      logic [CHAN_W-1:0] channel;
      logic              home_ok;
      logic [PAIR_W-1:0] home_pair;
   } lane_out_type;

   // All results caused by one poll, held until the output side takes them.
   typedef struct packed {
      logic [1:0]                n_samp;
      logic [CHAN_W-1:0]         chan0;
      logic signed [SAMPLE_W-1:0] val0;
      logic [CHAN_W-1:0]         chan1;
      logic signed [SAMPLE_W-1:0] val1;
      logic                      running;
      logic [ERR_W-1:0]          fail_streak;
      logic [RESTART_W-1:0]      restarts;
   } poll_rec_type;

endpackage

>>> rtl/dacs_if.sv
// Valid/ready channel interfaces: poll request, result, register write.
// Depends on dacs_pkg for field widths.
`timescale 1ns / 1ps
interface dacs_req_if;
   import dacs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [NOW_W-1:0]           now_ms;
   logic                       ready_first;
   logic                       ready_second;
   logic                       fail_first;
   logic                       fail_second;
   logic signed [SAMPLE_W-1:0] sample_first;
   logic signed [SAMPLE_W-1:0] sample_second;
   logic                       start_ok;

   modport source (output valid, now_ms, ready_first, ready_second, fail_first,
                   fail_second, sample_first, sample_second, start_ok,
                   input ready);
   modport sink (input valid, now_ms, ready_first, ready_second, fail_first,
                 fail_second, sample_first, sample_second, start_ok,
                 output ready);
endinterface

interface dacs_rsp_if;
   import dacs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       sample_valid;
   logic [CHAN_W-1:0]          chan_tag;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic                       is_running;
   logic [ERR_W-1:0]           fail_streak;
   logic [RESTART_W-1:0]       restarts_done;
   logic                       last_of_poll;

   modport source (output valid, sample_valid, chan_tag, sample_value,
                   is_running, fail_streak, restarts_done, last_of_poll,
                   input ready);
   modport sink (input valid, sample_valid, chan_tag, sample_value,
                 is_running, fail_streak, restarts_done, last_of_poll,
                 output ready);
endinterface

interface dacs_csr_if;
   import dacs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/dacs_lane.sv
// One converter lane: checks the current pair, decides sample/fail, finds the
// next enabled pair and the home pair. Depends on dacs_pkg.
`timescale 1ns / 1ps
module dacs_lane #(
   parameter int PAIRS_PER_CONVERTER = dacs_pkg::DEFAULT_PAIRS
) (
   input  logic                         present,
   input  logic [dacs_pkg::MASK_W-1:0]  mask,
   input  logic [dacs_pkg::CHAN_W-1:0]  base,
   input  logic [dacs_pkg::PAIR_W-1:0]  cur_pair,
   input  logic                         conv_ready,
   input  logic                         conv_fail,
   output dacs_pkg::lane_out_type       lane_out
);
   import dacs_pkg::*;

   localparam logic [CHAN_W:0] PAIRS_N = (CHAN_W+1)'(PAIRS_PER_CONVERTER);

   // Pair is inside the converter and its logical channel bit is set.
   function automatic logic pair_on(input logic [PAIR_W-1:0] pair);
      logic [CHAN_W:0] bit_idx;
      bit_idx = {1'b0, base} + {{(CHAN_W+1-PAIR_W){1'b0}}, pair};
      return ({{(CHAN_W+1-PAIR_W){1'b0}}, pair} < PAIRS_N) && (bit_idx <= 4'd7)
             && mask[bit_idx[CHAN_W-1:0]];
   endfunction

   // Round robin search from start; lowest offset wins.
   function automatic logic [PAIR_W:0] seek(input logic [PAIR_W-1:0] start);
      logic              found;
      logic [PAIR_W-1:0] hit;
      logic [CHAN_W:0]   sum;
      logic [PAIR_W-1:0] cand;
      found = 1'b0;
      hit   = '0;
      for (int off = 0; off < PAIRS_PER_CONVERTER; off++) begin
         sum  = {{(CHAN_W+1-PAIR_W){1'b0}}, start} + (CHAN_W+1)'(off);
         cand = (sum >= PAIRS_N) ? PAIR_W'(sum - PAIRS_N) : sum[PAIR_W-1:0];
         if (!found && pair_on(cand)) begin
            found = 1'b1;
            hit   = cand;
         end
      end
      return {found, hit};
   endfunction

   logic [CHAN_W:0]   step_sum;
   logic [PAIR_W-1:0] step_start;
   logic [PAIR_W:0]   next_seek;
   logic [PAIR_W:0]   home_seek;
   logic              accessed;

   // Next start pair wraps at the converter's pair count.
   assign step_sum   = {{(CHAN_W+1-PAIR_W){1'b0}}, cur_pair} + 4'd1;
   assign step_start = (step_sum >= PAIRS_N) ? '0 : step_sum[PAIR_W-1:0];
   assign next_seek  = seek(step_start);
   assign home_seek  = seek('0);
   assign accessed   = present && pair_on(cur_pair);

   always_comb begin
      lane_out.accessed  = accessed;
      lane_out.fail_hit  = accessed && conv_fail;
      lane_out.emit      = accessed && !conv_fail && conv_ready && next_seek[PAIR_W];
      lane_out.next_pair = next_seek[PAIR_W-1:0];
      lane_out.channel   = base + {{(CHAN_W-PAIR_W){1'b0}}, cur_pair};
      lane_out.home_ok   = present && home_seek[PAIR_W];
      lane_out.home_pair = home_seek[PAIR_W-1:0];
   end

endmodule

>>> rtl/dacs_rsp_queue.sv
// Two-poll result buffer: stores the results of one poll per slot, plays
// them out one transaction per cycle while ready. Uses dacs_pkg, dacs_if.
`timescale 1ns / 1ps
module dacs_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dacs_pkg::poll_rec_type push_rec,
   output logic                   full,
   dacs_rsp_if.source             rsp_ch
);
   import dacs_pkg::*;

   poll_rec_type rec_ff [2];
   poll_rec_type rec_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       sub_ff, sub_in;

   poll_rec_type head;
   logic         has_smp;
   logic         last;
   logic         pop_rsp;
   logic         pop_rec;

   assign head    = rec_ff[rd_ptr_ff];
   assign full    = (count_ff == 2'd2);
   assign has_smp = ({1'b0, sub_ff} < head.n_samp);
   assign last    = (head.n_samp <= 2'd1) || sub_ff;
   assign pop_rsp = rsp_ch.valid && rsp_ch.ready;
   assign pop_rec = pop_rsp && last;

   // Drive the current transaction from the head slot.
   always_comb begin
      rsp_ch.valid         = (count_ff != 2'd0);
      rsp_ch.sample_valid  = has_smp;
      rsp_ch.chan_tag      = !has_smp ? '0 : (sub_ff ? head.chan1 : head.chan0);
      rsp_ch.sample_value  = !has_smp ? '0 : (sub_ff ? head.val1 : head.val0);
      rsp_ch.is_running    = head.running;
      rsp_ch.fail_streak   = head.fail_streak;
      rsp_ch.restarts_done = head.restarts;
      rsp_ch.last_of_poll  = last;
   end

   // Advance pointers and the sub-result index.
   always_comb begin
      rec_in    = rec_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      sub_in    = sub_ff;
      count_in  = count_ff;
      if (push) begin
         rec_in[wr_ptr_ff] = push_rec;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop_rsp) begin
         sub_in = !last;
      end
      if (pop_rec) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop_rec};
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

endmodule

>>> rtl/dual_adc_channel_scan_sequencer.sv
// Top level of the dual converter scan sequencer: register file, two lanes,
// merge of lane results into shared state, result buffer.
// Depends on dacs_pkg, dacs_if, dacs_lane, dacs_rsp_queue, assert_macros.svh.
//
//  Channel  Dir  Carries                                 Transaction when
//  req_ch   in   poll time, ready/fail/sample x2, start  valid && ready
//  rsp_ch   out  sample, channel, status, last marker    valid && ready
//  csr_ch   in   register index and write data           valid && ready
//
// A poll is evaluated in the cycle it is accepted; its results are buffered
// and leave on rsp_ch one transaction per cycle while rsp_ch.ready is high.
// A poll that captures two samples takes two result transactions, so the
// result port sets the sustained poll rate. A two-poll buffer absorbs rsp_ch
// stalls; req_ch.ready drops when it is full or a register write is offered.
// Synchronous reset loads register defaults and scan state; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dual_adc_channel_scan_sequencer #(
   parameter int PAIRS_PER_CONVERTER = dacs_pkg::DEFAULT_PAIRS
) (
   input  logic        clock,
   input  logic        reset,
   dacs_req_if.sink    req_ch,
   dacs_rsp_if.source  rsp_ch,
   dacs_csr_if.sink    csr_ch
);
   import dacs_pkg::*;

   localparam logic [CHAN_W-1:0] PAIR_BASE = CHAN_W'(PAIRS_PER_CONVERTER);

   // Configuration registers.
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic                  en_first_ff, en_first_in;
   logic                  en_second_ff, en_second_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [ERR_W-1:0]      limit_ff, limit_in;

   // Scan state.
   logic                  running_ff, running_in;
   logic                  due_ff, due_in;
   logic [NOW_W-1:0]      last_ff, last_in;
   logic [ERR_W-1:0]      err_ff, err_in;
   logic [RESTART_W-1:0]  restart_ff, restart_in;
   logic [PAIR_W-1:0]     pair0_ff, pair0_in;
   logic [PAIR_W-1:0]     pair1_ff, pair1_in;

   logic          csr_fire;
   logic          req_fire;
   logic          mask_wr;
   logic          q_full;
   logic          retry_now;
   logic          any_fail;
   logic          emit0;
   logic          emit1;
   logic [ERR_W-1:0] err_sat;
   logic [MASK_W-1:0] lane_mask;
   logic [CHAN_W-1:0] base1;
   lane_out_type  lane0;
   lane_out_type  lane1;
   poll_rec_type  rec;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full && !csr_ch.valid;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign mask_wr      = csr_fire && (csr_ch.index == REG_CHANNEL_MASK);

   // Lanes see the new mask during a mask write so they can re-home.
   assign lane_mask = mask_wr ? csr_ch.data[MASK_W-1:0] : mask_ff;
   assign base1     = en_first_ff ? PAIR_BASE : '0;

   dacs_lane #(.PAIRS_PER_CONVERTER(PAIRS_PER_CONVERTER)) u_lane0 (
      .present    (en_first_ff),
      .mask       (lane_mask),
      .base       ('0),
      .cur_pair   (pair0_ff),
      .conv_ready (req_ch.ready_first),
      .conv_fail  (req_ch.fail_first),
      .lane_out   (lane0)
   );

   dacs_lane #(.PAIRS_PER_CONVERTER(PAIRS_PER_CONVERTER)) u_lane1 (
      .present    (en_second_ff),
      .mask       (lane_mask),
      .base       (base1),
      .cur_pair   (pair1_ff),
      .conv_ready (req_ch.ready_second),
      .conv_fail  (req_ch.fail_second),
      .lane_out   (lane1)
   );

   // Merge lane findings.
   assign emit0     = running_ff && lane0.emit;
   assign emit1     = running_ff && lane1.emit;
   assign any_fail  = lane0.fail_hit || lane1.fail_hit;
   assign err_sat   = (err_ff == ERR_MAX) ? ERR_MAX : err_ff + 8'd1;
   assign retry_now = due_ff || ((req_ch.now_ms - last_ff) >= {16'd0, interval_ff});

   // Next state for register writes and polls.
   always_comb begin
      mask_in      = mask_ff;
      en_first_in  = en_first_ff;
      en_second_in = en_second_ff;
      interval_in  = interval_ff;
      limit_in     = limit_ff;
      running_in   = running_ff;
      due_in       = due_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      restart_in   = restart_ff;
      pair0_in     = pair0_ff;
      pair1_in     = pair1_ff;
      if (csr_fire) begin
         case (csr_ch.index)
            REG_CHANNEL_MASK: begin
               mask_in = csr_ch.data[MASK_W-1:0];
               if (lane0.home_ok) pair0_in = lane0.home_pair;
               if (lane1.home_ok) pair1_in = lane1.home_pair;
            end
            REG_ENABLE_FIRST:   en_first_in  = csr_ch.data[0];
            REG_ENABLE_SECOND:  en_second_in = csr_ch.data[0];
            REG_RETRY_INTERVAL: interval_in  = csr_ch.data[INTERVAL_W-1:0];
            REG_ERROR_LIMIT:    limit_in     = csr_ch.data[ERR_W-1:0];
            default: ;
         endcase
      end else if (req_fire) begin
         if (!running_ff) begin
            // Stopped: attempt a restart when due.
            if (retry_now) begin
               err_in = '0;
               due_in = 1'b0;
               if (req_ch.start_ok) begin
                  running_in = 1'b1;
                  if (lane0.home_ok) pair0_in = lane0.home_pair;
                  if (lane1.home_ok) pair1_in = lane1.home_pair;
                  if (restart_ff != RESTART_MAX) restart_in = restart_ff + 16'd1;
               end else begin
                  last_in = req_ch.now_ms;
               end
            end
         end else begin
            // Running: advance lanes that captured, count failures.
            if (emit0) pair0_in = lane0.next_pair;
            if (emit1) pair1_in = lane1.next_pair;
            if (any_fail) begin
               err_in = err_sat;
               if (err_sat >= limit_ff) begin
                  running_in = 1'b0;
                  due_in     = 1'b1;
               end
            end else begin
               err_in = '0;
            end
         end
      end
   end

   // Pack the poll's results for the buffer.
   always_comb begin
      rec.n_samp      = {1'b0, emit0} + {1'b0, emit1};
      rec.chan0       = emit0 ? lane0.channel : lane1.channel;
      rec.val0        = emit0 ? req_ch.sample_first : req_ch.sample_second;
      rec.chan1       = lane1.channel;
      rec.val1        = req_ch.sample_second;
      rec.running     = running_in;
      rec.fail_streak = err_in;
      rec.restarts    = restart_in;
   end

   dacs_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_fire),
      .push_rec (rec),
      .full     (q_full),
      .rsp_ch   (rsp_ch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= MASK_RESET;
         en_first_ff  <= 1'b1;
         en_second_ff <= 1'b1;
         interval_ff  <= RETRY_RESET;
         limit_ff     <= LIMIT_RESET;
         running_ff   <= 1'b0;
         due_ff       <= 1'b1;
         last_ff      <= '0;
         err_ff       <= '0;
         restart_ff   <= '0;
         pair0_ff     <= '0;
         pair1_ff     <= '0;
      end else begin
         mask_ff      <= mask_in;
         en_first_ff  <= en_first_in;
         en_second_ff <= en_second_in;
         interval_ff  <= interval_in;
         limit_ff     <= limit_in;
         running_ff   <= running_in;
         due_ff       <= due_in;
         last_ff      <= last_in;
         err_ff       <= err_in;
         restart_ff   <= restart_in;
         pair0_ff     <= pair0_in;
         pair1_ff     <= pair1_in;
      end
   end

   // A stopped poll with no retry due leaves the failure count alone.
   `ASSERT_NEXT(a_err_hold, clock, reset, req_fire && !running_ff && !retry_now, $stable(err_ff))
   // Scanning only starts on a poll that was accepted with start_ok.
   `ASSERT_IMPLY(a_start_cause, clock, reset, $rose(running_ff), $past(req_fire && req_ch.start_ok))
   // The restart count moves only when scanning starts.
   `ASSERT_IMPLY(a_restart_rise, clock, reset, restart_ff != $past(restart_ff), $rose(running_ff))

endmodule

>>> verif/tb_dual_adc_channel_scan_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for dual_adc_channel_scan_sequencer: drives poll and register
// transactions, predicts each result with a behavioral scan model, checks in order.
// Depends on dacs_pkg, the dacs_if interfaces and the RTL top level.
module tb_dual_adc_channel_scan_sequencer;
   import dacs_pkg::*;

   localparam int PAIRS         = DEFAULT_PAIRS;
   localparam int IDLE_PCT      = 28;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [NOW_W-1:0]           now_ms;
      logic                       ready_first;
      logic                       ready_second;
      logic                       fail_first;
      logic                       fail_second;
      logic signed [SAMPLE_W-1:0] sample_first;
      logic signed [SAMPLE_W-1:0] sample_second;
      logic                       start_ok;
   } poll_item_type;

   typedef struct packed {
      logic                       sample_valid;
      logic [CHAN_W-1:0]          chan_tag;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       is_running;
      logic [ERR_W-1:0]           fail_streak;
      logic [RESTART_W-1:0]       restarts_done;
      logic                       last_of_poll;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dacs_req_if req_bus ();
   dacs_rsp_if rsp_bus ();
   dacs_csr_if csr_bus ();

   dual_adc_channel_scan_sequencer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Scan model: register copies and scan state
   logic [MASK_W-1:0]     chan_mask;
   logic                  first_on;
   logic                  second_on;
   logic [INTERVAL_W-1:0] retry_ms;
   logic [ERR_W-1:0]      err_limit;
   logic                  scan_running;
   logic                  retry_due;
   logic [NOW_W-1:0]      last_try_ms;
   logic [ERR_W-1:0]      err_count;
   logic [RESTART_W-1:0]  restart_count;
   logic [PAIR_W-1:0]     lane_pair [2];

   scan_result_type results_due [$];
   logic [NOW_W-1:0] poll_ms = '0;
   int  mismatches  = 0;
   int  cycle_count = 0;
   logic steady_flow = 1'b0;
   logic hold_flip   = 1'b0;
   logic hold_seen   = 1'b0;

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
   endtask

   function automatic logic lane_present(input int d);
      return (d == 0) ? first_on : second_on;
   endfunction

   // The second converter moves up by one bank when the first is present
   function automatic int lane_base(input int d);
      return (d != 0 && first_on) ? PAIRS : 0;
   endfunction

   function automatic logic pair_enabled(input int d, input int p);
      int bit_idx;
      bit_idx = lane_base(d) + p;
      if (p >= PAIRS || bit_idx > 7)
         return 1'b0;
      return chan_mask[bit_idx];
   endfunction

   // Round robin search from start for the next enabled pair
   function automatic logic seek_enabled_pair(input int d, input int start,
                                              output logic [PAIR_W-1:0] found);
      found = '0;
      for (int off = 0; off < PAIRS; off++) begin
         int cand;
         cand = (start + off) % PAIRS;
         if (pair_enabled(d, cand)) begin
            found = PAIR_W'(cand);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Move each present converter to its first enabled pair; keep it if none
   task automatic rehome_lanes();
      logic [PAIR_W-1:0] p;
      for (int d = 0; d < 2; d++)
         if (lane_present(d) && seek_enabled_pair(d, 0, p))
            lane_pair[d] = p;
   endtask

   task automatic reset_scan_model();
      chan_mask     = MASK_RESET;
      first_on      = 1'b1;
      second_on     = 1'b1;
      retry_ms      = RETRY_RESET;
      err_limit     = LIMIT_RESET;
      scan_running  = 1'b0;
      retry_due     = 1'b1;
      last_try_ms   = '0;
      err_count     = '0;
      restart_count = '0;
      lane_pair[0]  = '0;
      lane_pair[1]  = '0;
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      case (idx)
         REG_CHANNEL_MASK: begin
            chan_mask = v[MASK_W-1:0];
            rehome_lanes();
         end
         REG_ENABLE_FIRST:   first_on  = v[0];
         REG_ENABLE_SECOND:  second_on = v[0];
         REG_RETRY_INTERVAL: retry_ms  = v[INTERVAL_W-1:0];
         REG_ERROR_LIMIT:    err_limit = v[ERR_W-1:0];
         default: ;
      endcase
   endtask

   // Evaluate one poll and queue the results it causes
   task automatic advance_scan(input poll_item_type p);
      logic                lane_ready [2];
      logic                lane_fail [2];
      logic [SAMPLE_W-1:0] lane_sample [2];
      logic [CHAN_W-1:0]   cap_chan [2];
      logic [SAMPLE_W-1:0] cap_val [2];
      logic [PAIR_W-1:0]   cur;
      logic [PAIR_W-1:0]   nxt;
      logic [NOW_W-1:0]    since;
      int                  n_samp;
      int                  n_res;
      logic                any_fail;
      scan_result_type     r;
      lane_ready[0]  = p.ready_first;
      lane_ready[1]  = p.ready_second;
      lane_fail[0]   = p.fail_first;
      lane_fail[1]   = p.fail_second;
      lane_sample[0] = p.sample_first;
      lane_sample[1] = p.sample_second;
      cap_chan[0] = '0;
      cap_chan[1] = '0;
      cap_val[0]  = '0;
      cap_val[1]  = '0;
      n_samp   = 0;
      any_fail = 1'b0;
      since    = p.now_ms - last_try_ms;
      if (!scan_running) begin
         // stopped: attempt a restart when due
         if (retry_due || since >= {16'd0, retry_ms}) begin
            err_count = '0;
            retry_due = 1'b0;
            if (p.start_ok) begin
               scan_running = 1'b1;
               rehome_lanes();
               if (restart_count != RESTART_MAX)
                  restart_count++;
            end else begin
               last_try_ms = p.now_ms;
            end
         end
      end else begin
         // running: service each converter whose current pair is enabled
         for (int d = 0; d < 2; d++) begin
            cur = lane_pair[d];
            if (lane_present(d) && pair_enabled(d, int'(cur))) begin
               if (lane_fail[d]) begin
                  any_fail = 1'b1;
               end else if (lane_ready[d] &&
                            seek_enabled_pair(d, (int'(cur) + 1) % PAIRS, nxt)) begin
                  lane_pair[d]     = nxt;
                  cap_chan[n_samp] = CHAN_W'(lane_base(d) + int'(cur));
                  cap_val[n_samp]  = lane_sample[d];
                  n_samp++;
               end
            end
         end
         if (any_fail) begin
            if (err_count != ERR_MAX)
               err_count++;
            if (err_count >= err_limit) begin
               scan_running = 1'b0;
               retry_due    = 1'b1;
            end
         end else begin
            err_count = '0;
         end
      end
      n_res = (n_samp > 0) ? n_samp : 1;
      for (int k = 0; k < n_res; k++) begin
         r.sample_valid    = (k < n_samp);
         r.chan_tag        = (k < n_samp) ? cap_chan[k] : '0;
         r.sample_value    = (k < n_samp) ? cap_val[k] : '0;
         r.is_running      = scan_running;
         r.fail_streak     = err_count;
         r.restarts_done   = restart_count;
         r.last_of_poll    = (k == n_res - 1);
         results_due.push_back(r);
      end
   endtask

   // Check each result transaction against the oldest prediction
   always @(posedge clock) begin
      scan_result_type got;
      scan_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.sample_valid    = rsp_bus.sample_valid;
         got.chan_tag        = rsp_bus.chan_tag;
         got.sample_value    = rsp_bus.sample_value;
         got.is_running      = rsp_bus.is_running;
         got.fail_streak     = rsp_bus.fail_streak;
         got.restarts_done   = rsp_bus.restarts_done;
         got.last_of_poll    = rsp_bus.last_of_poll;
         if (results_due.size() == 0) begin
            report_mismatch("result with none pending", 32'(got.chan_tag), '0);
         end else begin
            want = results_due.pop_front();
            if (got.sample_valid !== want.sample_valid)
               report_mismatch("sample_valid", 32'(got.sample_valid), 32'(want.sample_valid));
            if (got.chan_tag !== want.chan_tag)
               report_mismatch("chan_tag", 32'(got.chan_tag), 32'(want.chan_tag));
            if (got.sample_value !== want.sample_value)
               report_mismatch("sample_value", 32'(unsigned'(got.sample_value)),
                               32'(unsigned'(want.sample_value)));
            if (got.is_running !== want.is_running)
               report_mismatch("is_running", 32'(got.is_running), 32'(want.is_running));
            if (got.fail_streak !== want.fail_streak)
               report_mismatch("fail_streak", 32'(got.fail_streak), 32'(want.fail_streak));
            if (got.restarts_done !== want.restarts_done)
               report_mismatch("restarts_done", 32'(got.restarts_done),
                               32'(want.restarts_done));
            if (got.last_of_poll !== want.last_of_poll)
               report_mismatch("last_of_poll", 32'(got.last_of_poll), 32'(want.last_of_poll));
         end
      end
   end

   // Drive result ready: random stalls, free flow, or one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_flip != hold_seen) begin
            hold_seen     = hold_flip;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (steady_flow) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   function automatic poll_item_type make_poll(input logic [NOW_W-1:0] now,
                                               input logic rf, input logic rs,
                                               input logic ff, input logic fs,
                                               input logic [SAMPLE_W-1:0] sf,
                                               input logic [SAMPLE_W-1:0] ss,
                                               input logic ok);
      poll_item_type p;
      p.now_ms        = now;
      p.ready_first   = rf;
      p.ready_second  = rs;
      p.fail_first    = ff;
      p.fail_second   = fs;
      p.sample_first  = sf;
      p.sample_second = ss;
      p.start_ok      = ok;
      poll_ms         = now;
      return p;
   endfunction

   // Mostly forward time steps, now and then a jump anywhere (wrap included)
   function automatic poll_item_type random_poll();
      poll_item_type p;
      if ($urandom_range(0, 99) < 5)
         poll_ms = $urandom;
      else
         poll_ms = poll_ms + $urandom_range(0, 300);
      p.now_ms        = poll_ms;
      p.ready_first   = ($urandom_range(0, 99) < 70);
      p.ready_second  = ($urandom_range(0, 99) < 70);
      p.fail_first    = ($urandom_range(0, 99) < 8);
      p.fail_second   = ($urandom_range(0, 99) < 8);
      p.sample_first  = SAMPLE_W'($urandom);
      p.sample_second = SAMPLE_W'($urandom);
      p.start_ok      = ($urandom_range(0, 99) < 75);
      return p;
   endfunction

   // Fill the bits above a field with noise; the block must ignore them
   function automatic logic [CSR_DATA_W-1:0] pad_reg(input logic [CSR_DATA_W-1:0] v,
                                                     input int keep);
      logic [CSR_DATA_W-1:0] low;
      low = 16'hFFFF >> (CSR_DATA_W - keep);
      return (CSR_DATA_W'($urandom) & ~low) | (v & low);
   endfunction

   // Offer one poll transaction; leaves valid high on return (at a falling edge)
   task automatic send_poll(input poll_item_type p);
      csr_bus.valid = 1'b0;
      if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.now_ms        = p.now_ms;
      req_bus.ready_first   = p.ready_first;
      req_bus.ready_second  = p.ready_second;
      req_bus.fail_first    = p.fail_first;
      req_bus.fail_second   = p.fail_second;
      req_bus.sample_first  = p.sample_first;
      req_bus.sample_second = p.sample_second;
      req_bus.start_ok      = p.start_ok;
      req_bus.valid         = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_scan(p);
      @(negedge clock);
   endtask

   task automatic run_polls(input int n);
      repeat (n) send_poll(random_poll());
   endtask

   // Stop offering and wait until every predicted result has arrived
   task automatic settle_results();
      req_bus.valid = 1'b0;
      csr_bus.valid = 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write transaction; valid stays high until the next drive step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_bus.index = idx;
      csr_bus.data  = v;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic write_defaults();
      write_reg(REG_ENABLE_FIRST, pad_reg(16'd1, 1));
      write_reg(REG_ENABLE_SECOND, pad_reg(16'd1, 1));
      write_reg(REG_RETRY_INTERVAL, 16'(RETRY_RESET));
      write_reg(REG_ERROR_LIMIT, pad_reg(16'(LIMIT_RESET), ERR_W));
      write_reg(REG_CHANNEL_MASK, pad_reg(16'(MASK_RESET), MASK_W));
   endtask

   // Restart timing right after reset, including a failed start
   task automatic test_restart_timing();
      send_poll(make_poll(32'd5, 1'b1, 1'b1, 1'b0, 1'b0, 24'h123456, 24'h654321, 1'b0));
      send_poll(make_poll(32'd500, 1'b1, 1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 1'b1));
      send_poll(make_poll(32'd1005, 1'b0, 1'b0, 1'b0, 1'b0, 24'hFFFFFF, 24'h0, 1'b1));
   endtask

   // Sample capture, failure priority over ready, error count and stop at limit
   task automatic test_sample_capture();
      send_poll(make_poll(32'd1010, 1'b1, 1'b1, 1'b0, 1'b0, 24'h800000, 24'h7FFFFF, 1'b0));
      send_poll(make_poll(32'd1020, 1'b1, 1'b1, 1'b0, 1'b0, 24'h7FFFFF, 24'h800000, 1'b0));
      send_poll(make_poll(32'd1030, 1'b1, 1'b1, 1'b0, 1'b0, 24'hFFFFFF, 24'h000000, 1'b1));
      send_poll(make_poll(32'd1040, 1'b0, 1'b0, 1'b0, 1'b0, 24'h111111, 24'h222222, 1'b1));
      send_poll(make_poll(32'd1050, 1'b0, 1'b1, 1'b0, 1'b0, 24'h0, 24'hABCDEF, 1'b1));
      send_poll(make_poll(32'd1060, 1'b1, 1'b0, 1'b1, 1'b0, 24'h333333, 24'h0, 1'b1));
      send_poll(make_poll(32'd1070, 1'b0, 1'b1, 1'b0, 1'b1, 24'h0, 24'h444444, 1'b1));
      send_poll(make_poll(32'd1080, 1'b1, 1'b0, 1'b0, 1'b0, 24'h555555, 24'h0, 1'b1));
      repeat (3)
         send_poll(make_poll(poll_ms + 32'd10, 1'b1, 1'b1, 1'b1, 1'b1, 24'h666666,
                             24'h777777, 1'b1));
   endtask

   // Retry interval measured across the wrap of the millisecond counter
   task automatic test_retry_wrap();
      send_poll(make_poll(32'hFFFF_FF00, 1'b1, 1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0));
      send_poll(make_poll(32'h0000_0200, 1'b1, 1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 1'b1));
      send_poll(make_poll(32'h0000_02F0, 1'b1, 1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 1'b1));
      send_poll(make_poll(32'h0000_0300, 1'b1, 1'b1, 1'b0, 1'b0, 24'hC0FFEE, 24'h0BEEF0,
                          1'b1));
   endtask

   // Walk the registers through their extremes and odd combinations
   task automatic test_register_sweep();
      settle_results();
      write_reg(REG_SPARE_FIRST, 16'hFFFF);
      write_reg(REG_SPARE_LAST, 16'hFFFF);
      write_reg(REG_CHANNEL_MASK, pad_reg(16'h00, MASK_W));
      run_polls(25);
      settle_results();
      write_reg(REG_CHANNEL_MASK, 16'hFF81);
      write_reg(REG_RETRY_INTERVAL, 16'd0);
      write_reg(REG_ERROR_LIMIT, pad_reg(16'd0, ERR_W));
      run_polls(30);
      settle_results();
      write_reg(REG_ENABLE_FIRST, pad_reg(16'd0, 1));
      write_reg(REG_CHANNEL_MASK, 16'h005A);
      write_reg(REG_ERROR_LIMIT, 16'd2);
      run_polls(30);
      settle_results();
      write_reg(REG_ENABLE_FIRST, pad_reg(16'd1, 1));
      write_reg(REG_ENABLE_SECOND, pad_reg(16'd0, 1));
      write_reg(REG_CHANNEL_MASK, pad_reg(16'hF0, MASK_W));
      run_polls(30);
      settle_results();
      write_reg(REG_ENABLE_SECOND, 16'hFFFF);
      write_reg(REG_RETRY_INTERVAL, 16'hFFFF);
      write_reg(REG_ERROR_LIMIT, pad_reg(16'd1, ERR_W));
      write_reg(REG_CHANNEL_MASK, pad_reg(16'h3C, MASK_W));
      run_polls(30);
      settle_results();
      write_defaults();
      run_polls(30);
   endtask

   // Long failure streak up to the largest limit
   task automatic test_error_saturation();
      poll_item_type p;
      settle_results();
      write_reg(REG_ERROR_LIMIT, 16'h00FF);
      write_reg(REG_RETRY_INTERVAL, 16'd0);
      write_reg(REG_CHANNEL_MASK, 16'h00FF);
      steady_flow <= 1'b1;
      send_poll(make_poll(poll_ms + 32'd1, 1'b1, 1'b1, 1'b0, 1'b0, 24'h0, 24'h0, 1'b1));
      repeat (257) begin
         p = random_poll();
         p.fail_first = 1'b1;
         send_poll(p);
      end
      steady_flow <= 1'b0;
      settle_results();
      write_reg(REG_ERROR_LIMIT, pad_reg(16'(LIMIT_RESET), ERR_W));
      run_polls(10);
   endtask

   // Receiver holds off while the sender keeps offering, then the sender drains
   task automatic test_output_stall();
      poll_item_type p;
      steady_flow <= 1'b1;
      hold_flip   <= ~hold_flip;
      repeat (40) begin
         p = random_poll();
         p.fail_first   = 1'b0;
         p.fail_second  = 1'b0;
         p.ready_first  = 1'b1;
         p.ready_second = 1'b1;
         p.start_ok     = 1'b1;
         send_poll(p);
      end
      steady_flow <= 1'b0;
      settle_results();
   endtask

   task automatic randomize_registers();
      logic                  mask_first;
      logic [MASK_W-1:0]     mask;
      logic [INTERVAL_W-1:0] retry;
      logic [ERR_W-1:0]      lim;
      int                    pick;
      pick = $urandom_range(0, 9);
      mask = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : MASK_W'($urandom);
      pick = $urandom_range(0, 9);
      retry = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
              (pick == 2) ? INTERVAL_W'($urandom) : INTERVAL_W'($urandom_range(0, 400));
      pick = $urandom_range(0, 19);
      lim = (pick < 2) ? 8'hFF : (pick == 2) ? ERR_W'($urandom) : ERR_W'($urandom_range(0, 8));
      mask_first = $urandom_range(0, 1);
      if (mask_first)
         write_reg(REG_CHANNEL_MASK, pad_reg(16'(mask), MASK_W));
      write_reg(REG_ENABLE_FIRST, pad_reg(16'($urandom_range(0, 99) < 80), 1));
      write_reg(REG_ENABLE_SECOND, pad_reg(16'($urandom_range(0, 99) < 80), 1));
      write_reg(REG_RETRY_INTERVAL, retry);
      write_reg(REG_ERROR_LIMIT, pad_reg(16'(lim), ERR_W));
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                   CSR_DATA_W'($urandom));
      if (!mask_first)
         write_reg(REG_CHANNEL_MASK, pad_reg(16'(mask), MASK_W));
   endtask

   // Random polls in chunks, each under a fresh register setting
   task automatic test_random_scan();
      for (int chunk = 0; chunk < 10; chunk++) begin
         settle_results();
         randomize_registers();
         steady_flow <= (chunk == 3);
         run_polls(100);
      end
      steady_flow <= 1'b0;
   endtask

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.now_ms        = '0;
      req_bus.ready_first   = 1'b0;
      req_bus.ready_second  = 1'b0;
      req_bus.fail_first    = 1'b0;
      req_bus.fail_second   = 1'b0;
      req_bus.sample_first  = '0;
      req_bus.sample_second = '0;
      req_bus.start_ok      = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      reset_scan_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_restart_timing();
      test_sample_capture();
      test_retry_wrap();
      test_register_sweep();
      test_error_saturation();
      test_output_stall();
      test_random_scan();

      settle_results();
      if (results_due.size() != 0)
         report_mismatch("results never delivered", 32'(results_due.size()), '0);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
